FILE: hw/rtl/ahu_pkg.sv
// ----------------------------------------------------------------------------
// ahu_pkg
// Shared constants, codes and the command type of the hold upsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package ahu_pkg;

    // Filter and run geometry
    localparam int HALF_TAPS    = 30;
    localparam int LINE_LEN     = 2 * HALF_TAPS - 1;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_RUN      = 32;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int COEF_FRAC = 17;
    localparam int IDX_W     = 5;
    localparam int OUT_W     = 20;
    localparam int STEP_W    = 22;
    localparam int CHAN_W    = 3;
    localparam int PHASE_W   = 16;

    // Derived widths
    localparam int PTR_W  = $clog2(LINE_LEN);
    localparam int K_W    = $clog2(HALF_TAPS);
    localparam int RUN_W  = $clog2(MAX_RUN + 1);
    localparam int PAIR_W = SAMPLE_W + 1;
    localparam int PROD_W = COEF_W + PAIR_W;
    localparam int ACC_W  = PROD_W + $clog2(HALF_TAPS);

    // Command queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Request codes
    localparam logic REQ_COEF  = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = STEP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANS = 1'b1;

    localparam logic [STEP_W-1:0] STEP_RESET = 22'd338820;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 3'd1;

    // One queued job for the filter engine
    typedef struct packed {
        logic                       is_coef;
        logic [IDX_W-1:0]           coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic signed [SAMPLE_W-1:0] mono;
        logic [RUN_W-1:0]           ticks;
    } t_cmd;

endpackage

`default_nettype wire

FILE: hw/rtl/ahu_in_if.sv
// ----------------------------------------------------------------------------
// ahu_in_if
// Request channel: coefficient writes and audio frames.
// ----------------------------------------------------------------------------
`default_nettype none

interface ahu_in_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [ahu_pkg::IDX_W-1:0]           coef_index;
    logic signed [ahu_pkg::COEF_W-1:0]   coef_value;
    logic signed [ahu_pkg::SAMPLE_W-1:0] sample_0;
    logic signed [ahu_pkg::SAMPLE_W-1:0] sample_1;
    logic signed [ahu_pkg::SAMPLE_W-1:0] sample_2;
    logic signed [ahu_pkg::SAMPLE_W-1:0] sample_3;

    modport source (
        output valid, req_type, coef_index, coef_value,
        output sample_0, sample_1, sample_2, sample_3,
        input  ready
    );
    modport sink (
        input  valid, req_type, coef_index, coef_value,
        input  sample_0, sample_1, sample_2, sample_3,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/ahu_out_if.sv
// ----------------------------------------------------------------------------
// ahu_out_if
// Result channel: one filtered output sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ahu_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ahu_pkg::OUT_W-1:0] baseband_sample;
    logic                             last_of_run;

    modport source (output valid, baseband_sample, last_of_run, input ready);
    modport sink   (input valid, baseband_sample, last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ahu_front.sv
// ----------------------------------------------------------------------------
// ahu_front
// Accepts requests, averages frames to mono, counts ticks, queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module ahu_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    ahu_in_if.sink                                i_in_ch,
    input  wire logic                             i_cfg_we,
    input  wire logic [ahu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [ahu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_full,
    output logic                                  o_push,
    output ahu_pkg::t_cmd                         o_cmd
);
    import ahu_pkg::*;

    localparam int SUM_W    = SAMPLE_W + $clog2(MAX_CHANNELS) + 1;
    localparam int DIV3_W   = 16;
    localparam int DIV3_SH  = 17;
    localparam logic [DIV3_W-1:0] DIV3_MUL = 16'd43691;  // ceil(2^17 / 3)
    localparam int Q_W      = STEP_W - PHASE_W + 1;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate                   r_state;
    logic [STEP_W-1:0]         r_step;
    logic [CHAN_W-1:0]         r_chans;
    logic [PHASE_W-1:0]        r_phase;
    logic [SUM_W-1:0]          r_mag;
    logic                      r_neg;
    logic [CHAN_W-1:0]         r_ch;
    t_cmd                      r_cmd;

    logic signed [SAMPLE_W-1:0] w_smp [MAX_CHANNELS];
    logic [CHAN_W-1:0]          w_ch;
    logic signed [SUM_W-1:0]    w_sum;
    logic [SUM_W-1:0]           w_mag;
    logic signed [STEP_W:0]     w_need;
    logic [STEP_W:0]            w_round;
    logic [Q_W-1:0]             w_q;
    logic [RUN_W-1:0]           w_ticks;
    logic [PHASE_W-1:0]         w_phase;
    logic [SUM_W+DIV3_W-1:0]    w_prod;
    logic [SUM_W-1:0]           w_quot;
    logic [SUM_W-1:0]           w_mono;

    assign w_smp[0] = i_in_ch.sample_0;
    assign w_smp[1] = i_in_ch.sample_1;
    assign w_smp[2] = i_in_ch.sample_2;
    assign w_smp[3] = i_in_ch.sample_3;

    assign i_in_ch.ready = (r_state == F_IDLE);
    assign o_push        = (r_state == F_PUSH) && !i_full;
    assign o_cmd         = r_cmd;

    // Channel average: sum, then divide the magnitude (truncates toward zero)
    always_comb begin
        if (r_chans == '0) begin
            w_ch = CHAN_W'(1);
        end else if (r_chans > CHAN_W'(MAX_CHANNELS)) begin
            w_ch = CHAN_W'(MAX_CHANNELS);
        end else begin
            w_ch = r_chans;
        end
        w_sum = '0;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            if (CHAN_W'(c) < w_ch) begin
                w_sum = w_sum + SUM_W'(w_smp[c]);
            end
        end
        w_mag = w_sum[SUM_W-1] ? unsigned'(-w_sum) : unsigned'(w_sum);
    end

    // Tick count from the phase accumulator
    always_comb begin
        w_need  = signed'({1'b0, r_step}) - signed'({{(STEP_W+1-PHASE_W){1'b0}}, r_phase});
        w_round = unsigned'(w_need) + (STEP_W+1)'(2**PHASE_W - 1);
        w_q     = w_round[STEP_W:PHASE_W];
        w_phase = r_phase - r_step[PHASE_W-1:0];
        if (w_need <= 0) begin
            w_ticks = '0;
        end else if (w_q > Q_W'(MAX_RUN)) begin
            w_ticks = RUN_W'(MAX_RUN);
            w_phase = '0;
        end else begin
            w_ticks = w_q[RUN_W-1:0];
        end
    end

    always_comb begin
        w_prod = r_mag * DIV3_MUL;
        case (r_ch)
            3'd2:    w_quot = r_mag >> 1;
            3'd3:    w_quot = SUM_W'(w_prod >> DIV3_SH);
            3'd4:    w_quot = r_mag >> 2;
            default: w_quot = r_mag;
        endcase
        w_mono = r_neg ? (~w_quot + 1'b1) : w_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= STEP_RESET;
            r_chans <= CHAN_RESET;
            r_phase <= '0;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_ch    <= CHAN_W'(1);
            r_cmd   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                    CFG_CHANS: r_chans <= i_cfg_data[CHAN_W-1:0];
                    default:   ;
                endcase
            end
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_ch.valid) begin
                        r_cmd.coef_index <= i_in_ch.coef_index;
                        r_cmd.coef_value <= i_in_ch.coef_value;
                        if (i_in_ch.req_type == REQ_COEF) begin
                            r_cmd.is_coef <= 1'b1;
                            r_cmd.ticks   <= '0;
                            r_state       <= F_PUSH;
                        end else begin
                            r_cmd.is_coef <= 1'b0;
                            r_cmd.ticks   <= w_ticks;
                            r_phase       <= w_phase;
                            r_mag         <= w_mag;
                            r_neg         <= w_sum[SUM_W-1];
                            r_ch          <= w_ch;
                            r_state       <= F_DIV;
                        end
                    end
                end
                F_DIV: begin
                    r_cmd.mono <= w_mono[SAMPLE_W-1:0];
                    // a frame that yields no tick leaves nothing to queue
                    r_state    <= (r_cmd.ticks == '0) ? F_IDLE : F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ahu_fifo.sv
// ----------------------------------------------------------------------------
// ahu_fifo
// Short job queue between the request front end and the filter engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ahu_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ahu_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output ahu_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import ahu_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ahu_fir.sv
// ----------------------------------------------------------------------------
// ahu_fir
// Filter engine: delay line, coefficient store, folded FIR, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ahu_fir (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire ahu_pkg::t_cmd i_cmd,
    output logic               o_pop,
    ahu_out_if.source          o_out_ch
);
    import ahu_pkg::*;

    localparam int X10_W = ACC_W + 4;
    localparam int FL_W  = X10_W - COEF_FRAC;

    typedef enum logic [2:0] {B_IDLE, B_WRITE, B_ISSUE, B_DRAIN, B_FINISH} t_bstate;

    t_bstate                     r_state;
    logic signed [SAMPLE_W-1:0]  r_mono;
    logic [RUN_W-1:0]            r_left;
    logic [PTR_W-1:0]            r_wptr;
    logic [PTR_W-1:0]            r_inc;
    logic [PTR_W-1:0]            r_dec;
    logic [K_W-1:0]              r_k;
    logic                        r_out_valid;
    logic signed [OUT_W-1:0]     r_out_sample;
    logic                        r_out_last;

    // delay line memory with per-entry valid bits (unwritten reads as zero)
    logic signed [SAMPLE_W-1:0]  r_dline [LINE_LEN];
    logic [LINE_LEN-1:0]         r_dvalid;
    logic signed [COEF_W-1:0]    r_coef [HALF_TAPS];

    // MAC pipeline
    logic                        r_s1_v, r_s2_v, r_s3_v;
    logic [K_W-1:0]              r_s1_k;
    logic signed [SAMPLE_W-1:0]  r_rd_a, r_rd_b;
    logic                        r_ok_a, r_ok_b;
    logic signed [PAIR_W-1:0]    r_pair;
    logic signed [COEF_W-1:0]    r_cf;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;

    logic                        w_dl_we;
    logic [PTR_W-1:0]            w_wptr_nx;
    logic signed [PAIR_W-1:0]    w_a, w_b;
    logic signed [X10_W-1:0]     w_acc_ext;
    logic signed [X10_W-1:0]     w_x10;
    logic signed [FL_W-1:0]      w_fl;
    logic signed [OUT_W-1:0]     w_sat;
    logic                        w_load;

    assign o_pop     = (r_state == B_IDLE) && i_valid;
    assign w_dl_we   = (r_state == B_WRITE);
    assign w_wptr_nx = (r_wptr == PTR_W'(LINE_LEN - 1)) ? '0 : r_wptr + 1'b1;
    assign w_load    = (r_state == B_FINISH) && (!r_out_valid || o_out_ch.ready);

    assign o_out_ch.valid           = r_out_valid;
    assign o_out_ch.baseband_sample = r_out_sample;
    assign o_out_ch.last_of_run     = r_out_last;

    // Coefficient store; out-of-range slots are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HALF_TAPS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (o_pop && i_cmd.is_coef && (i_cmd.coef_index < IDX_W'(HALF_TAPS))) begin
            r_coef[i_cmd.coef_index[K_W-1:0]] <= i_cmd.coef_value;
        end
    end

    // Delay line: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_dl_we) begin
            r_dline[r_wptr] <= r_mono;
        end
        r_rd_a <= r_dline[r_inc];
        r_rd_b <= r_dline[r_dec];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
            r_ok_a   <= 1'b0;
            r_ok_b   <= 1'b0;
        end else begin
            if (w_dl_we) begin
                r_dvalid[r_wptr] <= 1'b1;
            end
            r_ok_a <= r_dvalid[r_inc];
            r_ok_b <= r_dvalid[r_dec];
        end
    end

    // MAC pipeline: read -> pair sum -> product -> accumulate
    assign w_a = r_ok_a ? PAIR_W'(r_rd_a) : '0;
    assign w_b = r_ok_b ? PAIR_W'(r_rd_b) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == B_ISSUE);
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_k <= r_k;
        r_pair <= w_a + w_b;
        r_cf   <= r_coef[r_s1_k];
        r_prod <= r_cf * r_pair;
        if (r_state == B_WRITE) begin
            r_acc <= '0;
        end else if (r_s3_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Scale by ten, floor to Q15, saturate
    always_comb begin
        w_acc_ext = X10_W'(r_acc);
        w_x10     = (w_acc_ext <<< 3) + (w_acc_ext <<< 1);
        w_fl      = w_x10[X10_W-1:COEF_FRAC];
        if (w_fl[FL_W-1:OUT_W-1] == '0 || w_fl[FL_W-1:OUT_W-1] == '1) begin
            w_sat = w_fl[OUT_W-1:0];
        end else begin
            w_sat = w_fl[FL_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_mono       <= '0;
            r_left       <= '0;
            r_wptr       <= '0;
            r_inc        <= '0;
            r_dec        <= '0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
            r_out_sample <= '0;
            r_out_last   <= 1'b0;
        end else begin
            if (r_out_valid && o_out_ch.ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_valid && !i_cmd.is_coef) begin
                        r_mono  <= i_cmd.mono;
                        r_left  <= i_cmd.ticks;
                        r_state <= B_WRITE;
                    end
                end
                B_WRITE: begin
                    r_wptr  <= w_wptr_nx;
                    r_inc   <= w_wptr_nx;
                    r_dec   <= r_wptr;
                    r_k     <= '0;
                    r_state <= B_ISSUE;
                end
                B_ISSUE: begin
                    r_inc <= (r_inc == PTR_W'(LINE_LEN - 1)) ? '0 : r_inc + 1'b1;
                    r_dec <= (r_dec == '0) ? PTR_W'(LINE_LEN - 1) : r_dec - 1'b1;
                    r_k   <= r_k + 1'b1;
                    if (r_k == K_W'(HALF_TAPS - 1)) begin
                        r_state <= B_DRAIN;
                    end
                end
                B_DRAIN: begin
                    if (!r_s1_v && !r_s2_v && !r_s3_v) begin
                        r_state <= B_FINISH;
                    end
                end
                B_FINISH: begin
                    if (w_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= w_sat;
                        r_out_last   <= (r_left == RUN_W'(1));
                        r_left       <= r_left - 1'b1;
                        r_state      <= (r_left == RUN_W'(1)) ? B_IDLE : B_WRITE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr < PTR_W'(LINE_LEN)) && (r_inc < PTR_W'(LINE_LEN)) && (r_dec < PTR_W'(LINE_LEN)))
        else $error("delay line pointer out of range");

    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FINISH) |-> (!r_s1_v && !r_s2_v && !r_s3_v))
        else $error("output formed before the MAC pipeline drained");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_WRITE) |-> (r_left != '0))
        else $error("tick started with an empty run count");

endmodule

`default_nettype wire

FILE: hw/rtl/audio_hold_upsampler_fir_lowpass.sv
// ----------------------------------------------------------------------------
// audio_hold_upsampler_fir_lowpass
// Hold-and-filter audio interpolator with a folded symmetric low-pass FIR.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_ch carries coefficient writes (req_type 0) and audio frames
//   (req_type 1); a transfer happens when valid and ready are both high.
//   o_out_ch delivers one filtered sample per output tick, last_of_run
//   marking the final tick of a frame. Coefficient writes and frames with
//   zero ticks produce nothing.
//   i_cfg_we/i_cfg_idx/i_cfg_data write upsample_step (0) and
//   channel_count (1); write only while the block is idle.
// Flow:
//   The front end accepts no new request until it is done with the current
//   one, and queues each job (4 deep).
//   Each output tick in the filter engine takes one delay-line write, 30
//   tap-pair reads on the two memory read ports, the MAC pipeline drain
//   and one output load, in that order. The engine takes its next job
//   only after the last tick of a frame.
// Reset:
//   Synchronous, active low. Coefficients, phase and pointer clear at once;
//   the delay line is cleared through per-entry valid bits, no sweep.
// Stall:
//   A held output keeps the engine waiting at its load step; the queue and
//   front end keep taking requests until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_hold_upsampler_fir_lowpass (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    ahu_in_if.sink                                i_in_ch,
    ahu_out_if.source                             o_out_ch,
    input  wire logic                             i_cfg_we,
    input  wire logic [ahu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [ahu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ahu_pkg::*;

    // front end -> queue
    logic w_push;
    logic w_full;
    t_cmd w_push_cmd;

    // queue -> filter engine
    logic w_job_valid;
    logic w_job_pop;
    t_cmd w_job_cmd;

    // Request decode, mono average and tick count
    ahu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (i_in_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // Decoupling queue; keeps request order for coefficient writes and frames
    ahu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_cmd   (w_job_cmd),
        .i_pop   (w_job_pop)
    );

    // Tick sequencer, FIR MAC and output register
    ahu_fir u_fir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_job_valid),
        .i_cmd    (w_job_cmd),
        .o_pop    (w_job_pop),
        .o_out_ch (o_out_ch)
    );

endmodule

`default_nettype wire
